// File: rtl/core/bls_pkg.sv
// Shared types and codes for the bounded LIFO stack.
package bls_pkg;

    typedef enum logic [2:0] {
        REQ_PUSH    = 3'd0,
        REQ_POP     = 3'd1,
        REQ_PEEK    = 3'd2,
        REQ_UPDATE  = 3'd3,
        REQ_DISPLAY = 3'd4
    } req_e;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_BADIDX   = 2'd3
    } status_e;

    // What the back end does with a queued request.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_WALK  = 2'd3
    } op_kind_e;

    typedef struct packed {
        op_kind_e kind;
        status_e  status;
    } cmd_ctl_t;

    localparam int CTL_W  = $bits(cmd_ctl_t);
    localparam int WORD_W = 32;

endpackage

// File: rtl/core/bls_front.sv
// Front end: takes requests, tracks the fill count and classifies each request.
module bls_front #(
    parameter int DEPTH = 8,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [2:0]               req_type,
    input  logic [CW-1:0]            depth_index,
    output bls_pkg::cmd_ctl_t        cmd_ctl,
    output logic [AW-1:0]            cmd_addr,
    output logic [CW-1:0]            cmd_count
);
    import bls_pkg::*;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] count_m1;
    logic [CW-1:0] upd_pos;
    logic          empty;
    logic          full;

    assign count_m1 = count_reg - CW'(1);
    assign upd_pos  = count_reg - depth_index;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));

    always_comb
    begin
        count_next     = count_reg;
        cmd_ctl.kind   = OP_NONE;
        cmd_ctl.status = ST_OK;
        cmd_addr       = count_m1[AW-1:0];
        unique case (req_e'(req_type))
            REQ_PUSH:
            begin
                if (full)
                begin
                    cmd_ctl.status = ST_OVERFLOW;
                end
                else
                begin
                    cmd_ctl.kind = OP_WRITE;
                    cmd_addr     = count_reg[AW-1:0];
                    count_next   = count_reg + CW'(1);
                end
            end
            REQ_POP:
            begin
                if (empty)
                begin
                    cmd_ctl.status = ST_EMPTY;
                end
                else
                begin
                    cmd_ctl.kind = OP_READ;
                    count_next   = count_m1;
                end
            end
            REQ_PEEK:
            begin
                if (empty)
                    cmd_ctl.status = ST_EMPTY;
                else
                    cmd_ctl.kind = OP_READ;
            end
            REQ_UPDATE:
            begin
                if (depth_index == '0 || depth_index > count_reg)
                begin
                    cmd_ctl.status = ST_BADIDX;
                end
                else
                begin
                    cmd_ctl.kind = OP_WRITE;
                    cmd_addr     = upd_pos[AW-1:0];
                end
            end
            REQ_DISPLAY:
            begin
                if (empty)
                    cmd_ctl.status = ST_EMPTY;
                else
                    cmd_ctl.kind = OP_WALK;
            end
            default:
            begin
                cmd_ctl.status = ST_OK;
            end
        endcase
    end

    assign cmd_count = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (accept)
            count_reg <= count_next;
    end

endmodule

// File: rtl/core/bls_queue.sv
// Two-entry request queue between the front and back ends.
module bls_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             full,
    output logic             empty
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       level_reg;
    logic [1:0]       level_next;

    assign full  = (level_reg == 2'd2);
    assign empty = (level_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
            level_next = level_reg + 2'd1;
        else if (pop && !push)
            level_next = level_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            level_reg <= level_next;
        end
    end

endmodule

// File: rtl/core/bls_back.sv
// Back end: holds the entry memory, carries out queued requests, drives results.
module bls_back #(
    parameter int DEPTH = 8,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      head_valid,
    input  bls_pkg::cmd_ctl_t         head_ctl,
    input  logic [AW-1:0]             head_addr,
    input  logic [CW-1:0]             head_count,
    input  logic [31:0]               head_wdata,
    output logic                      head_pop,
    output logic                      strobe,
    output logic signed [31:0]        data,
    output logic [CW-1:0]             count,
    output logic [1:0]                status,
    output logic                      last
);
    import bls_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] cur_addr;
    logic          issue;
    logic          issue_last;

    logic          walk_reg;
    logic          walk_next;
    logic [AW-1:0] walk_ptr_reg;
    logic [AW-1:0] walk_ptr_next;

    logic          res_valid_reg;
    logic          res_sel_reg;
    logic [CW-1:0] res_count_reg;
    status_e       res_status_reg;
    logic          res_last_reg;

    assign cur_addr = walk_reg ? walk_ptr_reg : head_addr;

    always_comb
    begin
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        issue         = head_valid;
        issue_last    = 1'b1;
        head_pop      = head_valid;
        walk_next     = walk_reg;
        walk_ptr_next = walk_ptr_reg;
        if (head_valid)
        begin
            unique case (head_ctl.kind)
                OP_NONE:  ;
                OP_WRITE: wr_en = 1'b1;
                OP_READ:  rd_en = 1'b1;
                OP_WALK:
                begin
                    // step down one entry a cycle; hold the request until the bottom
                    rd_en         = 1'b1;
                    issue_last    = (cur_addr == '0);
                    head_pop      = (cur_addr == '0);
                    walk_next     = (cur_addr != '0);
                    walk_ptr_next = cur_addr - AW'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[cur_addr] <= head_wdata;
        if (rd_en)
            rd_data_reg <= mem[cur_addr];
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            res_count_reg  <= head_count;
            res_status_reg <= head_ctl.status;
            res_last_reg   <= issue_last;
            res_sel_reg    <= rd_en;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            walk_reg      <= 1'b0;
            walk_ptr_reg  <= '0;
        end
        else
        begin
            res_valid_reg <= issue;
            walk_reg      <= walk_next;
            walk_ptr_reg  <= walk_ptr_next;
        end
    end

    assign strobe = res_valid_reg;
    assign data   = res_sel_reg ? signed'(rd_data_reg) : '0;
    assign count  = res_count_reg;
    assign status = res_status_reg;
    assign last   = res_last_reg;

endmodule

// File: rtl/core/bounded_lifo_stack.sv
// Top level of the bounded LIFO stack.
// A request (push, pop, peek, update or display) is taken when start is high and busy
// is low; results come out on strobe, one per cycle, and must be taken as they appear.
// Push, pop, peek and update give one result each, registered in the request queue and
// then in the back end's result registers; display gives one result per held entry, top
// first, on consecutive cycles, the final one with last set. The back end runs one memory
// access per cycle, and a display holds the back end for one access per entry held; busy
// rises while the two-entry request queue is full. The entry memory needs no clearing
// after reset.
module bounded_lifo_stack #(
    parameter int DEPTH = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         req_type,
    input  logic signed [31:0]                 value,
    input  logic [$clog2(DEPTH + 1)-1:0]       depth_index,
    output logic                               strobe,
    output logic signed [31:0]                 data,
    output logic [$clog2(DEPTH + 1)-1:0]       count,
    output logic [1:0]                         status,
    output logic                               last
);
    import bls_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int QW = CTL_W + AW + CW + WORD_W;

    logic          accept;
    cmd_ctl_t      cmd_ctl;
    logic [AW-1:0] cmd_addr;
    logic [CW-1:0] cmd_count;

    logic [QW-1:0] q_head;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;

    cmd_ctl_t          head_ctl;
    logic [AW-1:0]     head_addr;
    logic [CW-1:0]     head_count;
    logic [WORD_W-1:0] head_wdata;

    assign busy   = q_full;
    assign accept = start && !q_full;

    bls_front #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req_type    (req_type),
        .depth_index (depth_index),
        .cmd_ctl     (cmd_ctl),
        .cmd_addr    (cmd_addr),
        .cmd_count   (cmd_count)
    );

    bls_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data ({cmd_ctl, cmd_addr, cmd_count, unsigned'(value)}),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign {head_ctl, head_addr, head_count, head_wdata} = q_head;

    bls_back #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!q_empty),
        .head_ctl   (head_ctl),
        .head_addr  (head_addr),
        .head_count (head_count),
        .head_wdata (head_wdata),
        .head_pop   (q_pop),
        .strobe     (strobe),
        .data       (data),
        .count      (count),
        .status     (status),
        .last       (last)
    );

endmodule

// File: rtl/core/bls_checker.sv
// Port-level checks for the bounded LIFO stack, bound to the top level.
module bls_checker #(
    parameter int DEPTH = 8
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               strobe,
    input logic signed [31:0]                 data,
    input logic [$clog2(DEPTH + 1)-1:0]       count,
    input logic [1:0]                         status,
    input logic                               last
);
    import bls_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // a failed request ends at once with a zero word
    a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status != ST_OK) |-> last && (data == '0))
        else $error("failed request did not end with a single zero result");

    // a display walk never pauses
    a_walk_continues: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("display walk left a gap");

    // the count holds across one display walk
    a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> count == $past(count))
        else $error("count changed within a display walk");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> count <= CW'(DEPTH))
        else $error("count above depth");

endmodule

bind bounded_lifo_stack bls_checker #(.DEPTH(DEPTH)) u_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bounded LIFO stack: directed table, then random requests.
module tb;
    import bls_pkg::*;

    localparam int STACK_DEPTH = 8;
    localparam int IDX_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_REQS = 126;
    localparam int DIR_ROWS    = 24;

    // Request codes the block does not define; they must answer ok and change nothing.
    localparam logic [2:0] REQ_RSV5 = 3'd5;
    localparam logic [2:0] REQ_RSV6 = 3'd6;
    localparam logic [2:0] REQ_RSV7 = 3'd7;

    localparam logic [31:0] MAX_POS  = 32'h7fff_ffff;
    localparam logic [31:0] MIN_NEG  = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    typedef struct packed {
        logic [31:0]      data;
        logic [IDX_W-1:0] cnt;
        status_e          st;
        logic             lst;
    } stack_result_t;

    typedef struct packed {
        logic [2:0]       req;
        logic [31:0]      val;
        logic [IDX_W-1:0] idx;
        logic             typed;
        logic [31:0]      data;
        logic [IDX_W-1:0] cnt;
        status_e          st;
    } dir_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [2:0]               req_type;
    logic signed [31:0]       value;
    logic [IDX_W-1:0]         depth_index;
    logic                     strobe;
    logic signed [31:0]       data;
    logic [IDX_W-1:0]         count;
    logic [1:0]               status;
    logic                     last;

    logic [31:0]   stack_mem [STACK_DEPTH];
    int            fill_level;
    stack_result_t expected_results [$];
    int            mismatch_count;
    int            idle_cycles;
    bit            back_to_back;

    // Rows with typed set carry the single result expected; the rest use the predictor.
    dir_row_t dir_tbl [DIR_ROWS] = '{
        '{REQ_POP,     32'd0,         4'd0,  1'b1, 32'd0,         4'd0, ST_EMPTY},
        '{REQ_PEEK,    32'd0,         4'd0,  1'b1, 32'd0,         4'd0, ST_EMPTY},
        '{REQ_DISPLAY, 32'd0,         4'd0,  1'b1, 32'd0,         4'd0, ST_EMPTY},
        '{REQ_UPDATE,  32'd5,         4'd1,  1'b1, 32'd0,         4'd0, ST_BADIDX},
        '{REQ_RSV7,    ALL_ONES,      4'd15, 1'b1, 32'd0,         4'd0, ST_OK},
        '{REQ_PUSH,    MAX_POS,       4'd0,  1'b1, 32'd0,         4'd1, ST_OK},
        '{REQ_PUSH,    MIN_NEG,       4'd0,  1'b1, 32'd0,         4'd2, ST_OK},
        '{REQ_PUSH,    ALL_ONES,      4'd0,  1'b1, 32'd0,         4'd3, ST_OK},
        '{REQ_PUSH,    32'd0,         4'd0,  1'b1, 32'd0,         4'd4, ST_OK},
        '{REQ_PUSH,    32'h5555_5555, 4'd0,  1'b1, 32'd0,         4'd5, ST_OK},
        '{REQ_PUSH,    32'haaaa_aaaa, 4'd0,  1'b1, 32'd0,         4'd6, ST_OK},
        '{REQ_PUSH,    32'd1,         4'd0,  1'b1, 32'd0,         4'd7, ST_OK},
        '{REQ_PUSH,    32'h1234_5678, 4'd15, 1'b1, 32'd0,         4'd8, ST_OK},
        '{REQ_PUSH,    32'hdead_beef, 4'd0,  1'b1, 32'd0,         4'd8, ST_OVERFLOW},
        '{REQ_PEEK,    32'd0,         4'd0,  1'b1, 32'h1234_5678, 4'd8, ST_OK},
        '{REQ_UPDATE,  32'h0bad_0bad, 4'd0,  1'b1, 32'd0,         4'd8, ST_BADIDX},
        '{REQ_UPDATE,  32'h0bad_0bad, 4'd9,  1'b1, 32'd0,         4'd8, ST_BADIDX},
        '{REQ_UPDATE,  32'h0bad_0bad, 4'd15, 1'b1, 32'd0,         4'd8, ST_BADIDX},
        '{REQ_UPDATE,  32'hcafe_f00d, 4'd8,  1'b1, 32'd0,         4'd8, ST_OK},
        '{REQ_UPDATE,  32'hffff_fffe, 4'd1,  1'b1, 32'd0,         4'd8, ST_OK},
        '{REQ_DISPLAY, 32'd0,         4'd0,  1'b0, 32'd0,         4'd0, ST_OK},
        '{REQ_POP,     32'd0,         4'd0,  1'b1, 32'hffff_fffe, 4'd7, ST_OK},
        '{REQ_RSV5,    32'd0,         4'd0,  1'b1, 32'd0,         4'd7, ST_OK},
        '{REQ_RSV6,    32'd0,         4'd0,  1'b1, 32'd0,         4'd7, ST_OK}
    };

    bounded_lifo_stack #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .value      (value),
        .depth_index(depth_index),
        .strobe     (strobe),
        .data       (data),
        .count      (count),
        .status     (status),
        .last       (last)
    );

    always #2 clk = ~clk;

    task automatic note_mismatch(string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Apply one request to the stack image and queue the results it must produce.
    task automatic stack_apply(logic [2:0] req, logic [31:0] val, logic [IDX_W-1:0] idx);
        stack_result_t r;
        bit            walked;
        r = '{data: '0, cnt: '0, st: ST_OK, lst: 1'b1};
        walked = 1'b0;
        case (req)
            REQ_PUSH:
                if (fill_level >= STACK_DEPTH)
                    r.st = ST_OVERFLOW;
                else
                begin
                    stack_mem[fill_level] = val;
                    fill_level++;
                end
            REQ_POP:
                if (fill_level == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    fill_level--;
                    r.data = stack_mem[fill_level];
                end
            REQ_PEEK:
                if (fill_level == 0)
                    r.st = ST_EMPTY;
                else
                    r.data = stack_mem[fill_level - 1];
            REQ_UPDATE:
                if (idx == 0 || idx > fill_level)
                    r.st = ST_BADIDX;
                else
                    stack_mem[fill_level - idx] = val;
            REQ_DISPLAY:
                if (fill_level == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    walked = 1'b1;
                    for (int i = 0; i < fill_level; i++)
                    begin
                        r.data = stack_mem[fill_level - 1 - i];
                        r.cnt  = IDX_W'(fill_level);
                        r.lst  = (i == fill_level - 1);
                        expected_results.push_back(r);
                    end
                end
            default: ;
        endcase
        if (!walked)
        begin
            r.cnt = IDX_W'(fill_level);
            expected_results.push_back(r);
        end
    endtask

    // Present one request after a random gap and hold it until the block takes it.
    task automatic issue(logic [2:0] req, logic [31:0] val, logic [IDX_W-1:0] idx);
        int gap;
        if ($urandom_range(0, 15) == 0)
            back_to_back = !back_to_back;
        gap = back_to_back ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        req_type    <= req;
        value       <= val;
        depth_index <= idx;
        do
            @(posedge clk);
        while (busy);
        stack_apply(req, val, idx);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return MAX_POS;
            1:       return MIN_NEG;
            2:       return ALL_ONES;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int               sel;
        logic [2:0]       req;
        logic [31:0]      val;
        logic [IDX_W-1:0] idx;
        rst_n          <= 1'b0;
        start          <= 1'b0;
        req_type       <= '0;
        value          <= '0;
        depth_index    <= '0;
        fill_level     = 0;
        mismatch_count = 0;
        back_to_back   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tbl[k])
        begin
            issue(dir_tbl[k].req, dir_tbl[k].val, dir_tbl[k].idx);
            if (dir_tbl[k].typed)
                expected_results[$] = '{data: dir_tbl[k].data, cnt: dir_tbl[k].cnt,
                                        st: dir_tbl[k].st, lst: 1'b1};
        end

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            sel = $urandom_range(0, 99);
            val = pick_word();
            idx = IDX_W'($urandom_range(0, 15));
            if (sel < 35)
                req = REQ_PUSH;
            else if (sel < 55)
                req = REQ_POP;
            else if (sel < 63)
                req = REQ_PEEK;
            else if (sel < 83)
            begin
                req = REQ_UPDATE;
                // Aim most updates at a live entry.
                if (fill_level != 0 && $urandom_range(0, 4) != 0)
                    idx = IDX_W'($urandom_range(1, fill_level));
            end
            else if (sel < 93)
                req = REQ_DISPLAY;
            else
                req = 3'($urandom_range(REQ_RSV5, REQ_RSV7));
            issue(req, val, idx);
        end
        start <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n && strobe)
        begin
            if (expected_results.size() == 0)
                note_mismatch($sformatf("unexpected result data=%h count=%0d status=%0d",
                                        data, count, status));
            else
            begin
                want = expected_results.pop_front();
                if (data !== want.data)
                    note_mismatch($sformatf("data %h, want %h", data, want.data));
                if (count !== want.cnt)
                    note_mismatch($sformatf("count %0d, want %0d", count, want.cnt));
                if (status !== want.st)
                    note_mismatch($sformatf("status %0d, want %0d", status, want.st));
                if (last !== want.lst)
                    note_mismatch($sformatf("last %b, want %b", last, want.lst));
            end
        end
    end

    // Abort when neither a request nor a result moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((start && !busy) || strobe)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// File: sim.f
rtl/core/bls_pkg.sv
rtl/core/bls_front.sv
rtl/core/bls_queue.sv
rtl/core/bls_back.sv
rtl/core/bounded_lifo_stack.sv
rtl/core/bls_checker.sv
tb/tb.sv
